// File: design/sbeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_pkg
// Shared types and constants of the stereo biquad equalizer and limiter.
// ----------------------------------------------------------------------------
package sbeq_pkg;

    localparam int SECTIONS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    localparam int COEF_SLOTS = 5;
    localparam int PRE_FRAC   = 20;
    localparam int Q24_FRAC   = 24;
    localparam int DIV_STEPS  = 24;
    localparam int GAIN_W     = 25;

    localparam logic [GAIN_W-1:0] UNITY = 25'h1000000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_SECTION_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMP_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_STEP        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_THRESHOLD = 3'd5;

    localparam logic [4:0]  RST_SECTION_COUNT   = 5'd0;
    localparam logic [23:0] RST_PREAMP_GAIN     = 24'd1048576;
    localparam logic        RST_BYPASS          = 1'b0;
    localparam logic [23:0] RST_WET_STEP        = 24'd34917;
    localparam logic [23:0] RST_RELEASE_STEP    = 24'd4369;
    localparam logic [22:0] RST_LIMIT_THRESHOLD = 23'd8220835;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RND_Q20,
        RND_COEF,
        RND_Q24
    } rnd_sel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/sbeq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sbeq_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_mac
// Shared signed multiplier with registered product and registered rounding,
// round to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module sbeq_mac #(
    parameter int MA        = 33,
    parameter int MB        = 32,
    parameter int COEF_FRAC = 26
) (
    input  logic                     aclk,
    input  logic signed [MA-1:0]     mul_a,
    input  logic signed [MB-1:0]     mul_b,
    input  sbeq_pkg::rnd_sel_t       sel,
    output logic signed [MA+MB-1:0]  rnd
);

    localparam int PW = MA + MB;

    logic signed [PW-1:0] prod_reg;
    sbeq_pkg::rnd_sel_t   sel_reg;
    logic signed [PW-1:0] rnd_reg;
    logic signed [PW-1:0] rnd_next;
    logic signed [PW-1:0] half_v;
    logic signed [PW-1:0] sum_v;

    always_comb begin
        case (sel_reg)
            sbeq_pkg::RND_Q20: half_v = $signed(PW'(1) << (sbeq_pkg::PRE_FRAC - 1));
            sbeq_pkg::RND_COEF: half_v = $signed(PW'(1) << (COEF_FRAC - 1));
            default: half_v = $signed(PW'(1) << (sbeq_pkg::Q24_FRAC - 1));
        endcase
        sum_v = prod_reg + half_v - $signed(PW'(prod_reg[PW-1]));
        case (sel_reg)
            sbeq_pkg::RND_Q20: rnd_next = sum_v >>> sbeq_pkg::PRE_FRAC;
            sbeq_pkg::RND_COEF: rnd_next = sum_v >>> COEF_FRAC;
            default: rnd_next = sum_v >>> sbeq_pkg::Q24_FRAC;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        sel_reg  <= sel;
        rnd_reg  <= rnd_next;
    end

    assign rnd = rnd_reg;

endmodule

// File: design/sbeq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_div
// Restoring divider for the limiter target, one quotient bit per cycle.
// Computes floor(num * 2^24 / den) for num < den.
// ----------------------------------------------------------------------------
module sbeq_div #(
    parameter int W = 33
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [W-1:0]                         num,
    input  logic [W-1:0]                         den,
    output logic [sbeq_pkg::DIV_STEPS-1:0]       quot,
    output sbeq_pkg::div_stat_t                  stat
);

    localparam int CW = $clog2(sbeq_pkg::DIV_STEPS + 1);

    logic [W:0]                       rem_reg, rem_next;
    logic [W-1:0]                     den_reg, den_next;
    logic [sbeq_pkg::DIV_STEPS-1:0]   quot_reg, quot_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [W:0]                       shifted;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], 1'b0};
        if (start) begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = CW'(sbeq_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next  = shifted - {1'b0, den_reg};
                quot_next = {quot_reg[sbeq_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                quot_next = {quot_reg[sbeq_pkg::DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/stereo_biquad_eq_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_eq_limiter
// Stereo cascaded biquad equalizer with wet/dry crossfade and shared peak
// limiter. Coefficients and section delays live in two RAMs, walked by one
// shared multiplier.
//
//   channel  | dir | handshake             | payload
//   s_       | in  | s_valid / s_ready     | mode, samples, coefficient write
//   m_       | out | m_valid / m_ready     | left_out, right_out, peak_level
//   cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The shared multiplier does one product per cycle and the target divider
// produces one bit per cycle. Each section reads its five coefficients and
// one delay entry from RAM and writes the entry back. Coefficient writes,
// delay clears and unused modes are handled in the idle state.
// Reset is synchronous; delay entries are zero through per-entry valid bits.
// A result waiting on m_ready holds the next item only at its output stage.
// ----------------------------------------------------------------------------
module stereo_biquad_eq_limiter #(
    parameter int SECTIONS    = sbeq_pkg::SECTIONS_DEF,
    parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sbeq_pkg::COEF_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_mode,
    input  logic signed [SAMPLE_BITS-1:0]         s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         s_right_sample,
    input  logic [3:0]                            s_coef_section,
    input  logic [2:0]                            s_coef_index,
    input  logic signed [COEF_BITS-1:0]           s_coef_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_left_out,
    output logic signed [SAMPLE_BITS-1:0]         m_right_out,
    output logic [SAMPLE_BITS-2:0]                m_peak_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sbeq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sbeq_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int S         = SAMPLE_BITS;
    localparam int SIGW      = S + 8;
    localparam int DLW       = S + 16;
    localparam int MIXW      = SIGW + 1;
    localparam int MAGW      = MIXW;
    localparam int MA        = (MIXW > 26) ? MIXW : 26;
    localparam int MB        = (COEF_BITS > 26) ? COEF_BITS : 26;
    localparam int PW        = MA + MB;
    localparam int AW        = PW + 2;
    localparam int COEF_FRAC = COEF_BITS - 6;
    localparam int CDEPTH    = sbeq_pkg::COEF_SLOTS * SECTIONS;
    localparam int CAW       = $clog2(CDEPTH);
    localparam int DDEPTH    = 2 * SECTIONS;
    localparam int DAW       = $clog2(DDEPTH);
    localparam int SECW      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CNTW      = $clog2(SECTIONS + 1);
    localparam int THR_LSH   = (S >= 24) ? S - 24 : 0;
    localparam int THR_RSH   = (S >= 24) ? 0 : 24 - S;
    localparam int GW        = sbeq_pkg::GAIN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WET,
        ST_PRE,
        ST_SEC,
        ST_MIX,
        ST_LIM,
        ST_DIV,
        ST_GAIN,
        ST_OUT,
        ST_EMIT
    } state_t;

    function automatic logic signed [AW-1:0] sat_n(input logic signed [AW-1:0] v, input int n);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = $signed((AW'(1) << (n - 1)) - AW'(1));
        lo = -hi - $signed(AW'(1));
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    state_t                  state_reg, state_next;
    logic [2:0]              ph_reg, ph_next;
    logic                    ch_reg, ch_next;
    logic [SECW-1:0]         sec_reg, sec_next;
    logic [CAW-1:0]          cbase_reg, cbase_next;
    logic signed [S-1:0]     dry_reg [2];
    logic signed [S-1:0]     dry_next [2];
    logic signed [SIGW-1:0]  xy_reg, xy_next;
    logic signed [PW-1:0]    t1_reg, t1_next;
    logic signed [PW-1:0]    t2_reg, t2_next;
    logic signed [PW-1:0]    acc_reg, acc_next;
    logic signed [DLW-1:0]   z1n_reg, z1n_next;
    logic signed [MIXW-1:0]  mix_reg [2];
    logic signed [MIXW-1:0]  mix_next [2];
    logic [MAGW-1:0]         p_reg, p_next;
    logic [GW-1:0]           target_reg, target_next;
    logic [GW-1:0]           wet_reg, wet_next;
    logic [GW-1:0]           gain_reg, gain_next;
    logic signed [S-1:0]     y_reg [2];
    logic signed [S-1:0]     y_next [2];
    logic [DDEPTH-1:0]       dvalid_reg, dvalid_next;

    logic [4:0]              sc_reg;
    logic [23:0]             pre_reg;
    logic                    byp_reg;
    logic [23:0]             wstep_reg;
    logic [23:0]             rstep_reg;
    logic [22:0]             thr_reg;

    logic                    m_valid_reg, m_valid_next;
    logic signed [S-1:0]     m_left_reg, m_left_next;
    logic signed [S-1:0]     m_right_reg, m_right_next;
    logic [S-2:0]            m_peak_reg, m_peak_next;

    logic                    accept;
    logic [CNTW-1:0]         cnt_eff;
    logic                    last_sec;
    logic [DAW-1:0]          daddr;
    logic                    zvalid;
    logic signed [DLW-1:0]   z1_eff, z2_eff;
    logic [MAGW-1:0]         thr_val;
    logic [MAGW-1:0]         mag0, mag1;
    logic [S-1:0]            ymag0, ymag1, ypk;
    logic [GW-1:0]           wet_goal;
    logic signed [GW:0]      wsum, gsum;

    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    sbeq_pkg::rnd_sel_t      mul_sel;
    logic signed [PW-1:0]    rnd;

    logic                    coef_we;
    logic [CAW-1:0]          coef_waddr;
    logic                    coef_re;
    logic [CAW-1:0]          coef_raddr;
    logic [COEF_BITS-1:0]    coef_rdata;
    logic                    dly_re, dly_we;
    logic [2*DLW-1:0]        dly_wdata, dly_rdata;

    logic                    div_start;
    logic [sbeq_pkg::DIV_STEPS-1:0] div_quot;
    sbeq_pkg::div_stat_t     div_stat;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // effective section count
    assign cnt_eff  = (32'(sc_reg) > SECTIONS) ? CNTW'(SECTIONS) : CNTW'(sc_reg);
    assign last_sec = ((32'(sec_reg) + 32'd1) == 32'(cnt_eff));
    assign daddr    = DAW'(ch_reg ? SECTIONS : 0) + DAW'(sec_reg);
    assign zvalid   = dvalid_reg[daddr];
    assign z1_eff   = zvalid ? $signed(dly_rdata[2*DLW-1:DLW]) : '0;
    assign z2_eff   = zvalid ? $signed(dly_rdata[DLW-1:0]) : '0;
    assign thr_val  = MAGW'((64'(thr_reg) >> THR_RSH) << THR_LSH);
    assign mag0     = MAGW'($unsigned(mix_reg[0][MIXW-1] ? -mix_reg[0] : mix_reg[0]));
    assign mag1     = MAGW'($unsigned(mix_reg[1][MIXW-1] ? -mix_reg[1] : mix_reg[1]));
    assign ymag0    = $unsigned(y_reg[0][S-1] ? -y_reg[0] : y_reg[0]);
    assign ymag1    = $unsigned(y_reg[1][S-1] ? -y_reg[1] : y_reg[1]);
    assign ypk      = (ymag0 > ymag1) ? ymag0 : ymag1;
    assign wet_goal = byp_reg ? '0 : sbeq_pkg::UNITY;
    assign wsum     = $signed({1'b0, wet_reg}) + (GW + 1)'(rnd);
    assign gsum     = $signed({1'b0, gain_reg}) + (GW + 1)'(rnd);

    // coefficient ram ports
    assign coef_we    = accept && (s_mode == sbeq_pkg::MODE_COEF)
                        && (32'(s_coef_index) < sbeq_pkg::COEF_SLOTS)
                        && (32'(s_coef_section) < SECTIONS);
    assign coef_waddr = CAW'(32'(s_coef_section) * sbeq_pkg::COEF_SLOTS + 32'(s_coef_index));
    assign coef_re    = (state_reg == ST_SEC) && (ph_reg <= 3'd4);
    assign coef_raddr = cbase_reg + CAW'(ph_reg);

    // delay ram ports
    assign dly_re    = (state_reg == ST_SEC) && (ph_reg == 3'd0);
    assign dly_we    = (state_reg == ST_SEC) && (ph_reg == 3'd7);
    assign dly_wdata = {z1n_reg, DLW'(sat_n(AW'(t2_reg) - AW'(rnd), DLW))};

    assign div_start = (state_reg == ST_LIM) && (ph_reg == 3'd1) && (p_reg > thr_val);

    // multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sel = sbeq_pkg::RND_Q24;
        case (state_reg)
            ST_WET: begin
                mul_a = MA'($signed({1'b0, wet_goal}) - $signed({1'b0, wet_reg}));
                mul_b = MB'($signed({1'b0, wstep_reg}));
            end
            ST_PRE: begin
                mul_a   = MA'(dry_reg[ch_reg]);
                mul_b   = MB'($signed({1'b0, pre_reg}));
                mul_sel = sbeq_pkg::RND_Q20;
            end
            ST_SEC: begin
                mul_a   = MA'(xy_reg);
                mul_b   = MB'($signed(coef_rdata));
                mul_sel = sbeq_pkg::RND_COEF;
            end
            ST_MIX: begin
                if (ph_reg == 3'd0) begin
                    mul_a = MA'(dry_reg[ch_reg]);
                    mul_b = MB'($signed({1'b0, sbeq_pkg::UNITY}) - $signed({1'b0, wet_reg}));
                end else begin
                    mul_a = MA'(xy_reg);
                    mul_b = MB'($signed({1'b0, wet_reg}));
                end
            end
            ST_GAIN: begin
                mul_a = MA'($signed({1'b0, target_reg}) - $signed({1'b0, gain_reg}));
                mul_b = MB'($signed({1'b0, rstep_reg}));
            end
            ST_OUT: begin
                mul_a = MA'(mix_reg[ph_reg[0]]);
                mul_b = MB'($signed({1'b0, gain_reg}));
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg + 3'd1;
        ch_next      = ch_reg;
        sec_next     = sec_reg;
        cbase_next   = cbase_reg;
        dry_next     = dry_reg;
        xy_next      = xy_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        acc_next     = acc_reg;
        z1n_next     = z1n_reg;
        mix_next     = mix_reg;
        p_next       = p_reg;
        target_next  = target_reg;
        wet_next     = wet_reg;
        gain_next    = gain_reg;
        y_next       = y_reg;
        dvalid_next  = dvalid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        m_peak_next  = m_peak_reg;

        case (state_reg)
            ST_IDLE: begin
                ph_next = '0;
                if (accept) begin
                    case (s_mode)
                        sbeq_pkg::MODE_SAMPLE: begin
                            dry_next[0] = s_left_sample;
                            dry_next[1] = s_right_sample;
                            ch_next     = 1'b0;
                            state_next  = ST_WET;
                        end
                        sbeq_pkg::MODE_CLEAR: begin
                            if (32'(s_coef_section) < SECTIONS) begin
                                dvalid_next[DAW'(s_coef_section)] = 1'b0;
                                dvalid_next[DAW'(32'(s_coef_section) + SECTIONS)] = 1'b0;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WET: begin
                if (ph_reg == 3'd2) begin
                    wet_next   = wsum[GW-1:0];
                    ph_next    = '0;
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (ph_reg == 3'd2) begin
                    xy_next    = SIGW'(sat_n(AW'(rnd), SIGW));
                    sec_next   = '0;
                    cbase_next = '0;
                    ph_next    = '0;
                    state_next = (cnt_eff == '0) ? ST_MIX : ST_SEC;
                end
            end
            ST_SEC: begin
                case (ph_reg)
                    3'd3: xy_next = SIGW'(sat_n(AW'(rnd) + AW'(z1_eff), SIGW));
                    3'd4: t1_next = rnd;
                    3'd5: t2_next = rnd;
                    3'd6: z1n_next = DLW'(sat_n(AW'(t1_reg) - AW'(rnd) + AW'(z2_eff), DLW));
                    3'd7: begin
                        dvalid_next[daddr] = 1'b1;
                        if (last_sec) begin
                            state_next = ST_MIX;
                        end else begin
                            sec_next   = sec_reg + SECW'(1);
                            cbase_next = cbase_reg + CAW'(sbeq_pkg::COEF_SLOTS);
                        end
                    end
                    default: begin
                        xy_next = xy_reg;
                    end
                endcase
            end
            ST_MIX: begin
                if (ph_reg == 3'd2) begin
                    acc_next = rnd;
                end else if (ph_reg == 3'd3) begin
                    mix_next[ch_reg] = MIXW'(AW'(acc_reg) + AW'(rnd));
                    ph_next = '0;
                    if (!ch_reg) begin
                        ch_next    = 1'b1;
                        state_next = ST_PRE;
                    end else begin
                        state_next = ST_LIM;
                    end
                end
            end
            ST_LIM: begin
                if (ph_reg == 3'd0) begin
                    p_next = (mag0 > mag1) ? mag0 : mag1;
                end else begin
                    ph_next = '0;
                    if (p_reg > thr_val) begin
                        state_next = ST_DIV;
                    end else begin
                        target_next = sbeq_pkg::UNITY;
                        state_next  = ST_GAIN;
                    end
                end
            end
            ST_DIV: begin
                ph_next = '0;
                if (div_stat.done) begin
                    target_next = {1'b0, div_quot};
                    state_next  = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (ph_reg == 3'd0) begin
                    if (target_reg < gain_reg) begin
                        gain_next  = target_reg;
                        ph_next    = '0;
                        state_next = ST_OUT;
                    end
                end else if (ph_reg == 3'd2) begin
                    gain_next  = gsum[GW-1:0];
                    ph_next    = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (ph_reg == 3'd2) begin
                    y_next[0] = S'(sat_n(AW'(rnd), S));
                end else if (ph_reg == 3'd3) begin
                    y_next[1]  = S'(sat_n(AW'(rnd), S));
                    ph_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                ph_next = '0;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_left_next  = y_reg[0];
                    m_right_next = y_reg[1];
                    m_peak_next  = ypk[S-1] ? '1 : ypk[S-2:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= '0;
            ch_reg      <= 1'b0;
            sec_reg     <= '0;
            cbase_reg   <= '0;
            wet_reg     <= sbeq_pkg::UNITY;
            gain_reg    <= sbeq_pkg::UNITY;
            dvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
            sc_reg      <= sbeq_pkg::RST_SECTION_COUNT;
            pre_reg     <= sbeq_pkg::RST_PREAMP_GAIN;
            byp_reg     <= sbeq_pkg::RST_BYPASS;
            wstep_reg   <= sbeq_pkg::RST_WET_STEP;
            rstep_reg   <= sbeq_pkg::RST_RELEASE_STEP;
            thr_reg     <= sbeq_pkg::RST_LIMIT_THRESHOLD;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            ch_reg      <= ch_next;
            sec_reg     <= sec_next;
            cbase_reg   <= cbase_next;
            wet_reg     <= wet_next;
            gain_reg    <= gain_next;
            dvalid_reg  <= dvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sbeq_pkg::REG_SECTION_COUNT:   sc_reg    <= cfg_data[4:0];
                    sbeq_pkg::REG_PREAMP_GAIN:     pre_reg   <= cfg_data[23:0];
                    sbeq_pkg::REG_BYPASS:          byp_reg   <= cfg_data[0];
                    sbeq_pkg::REG_WET_STEP:        wstep_reg <= cfg_data[23:0];
                    sbeq_pkg::REG_RELEASE_STEP:    rstep_reg <= cfg_data[23:0];
                    sbeq_pkg::REG_LIMIT_THRESHOLD: thr_reg   <= cfg_data[22:0];
                    default: begin
                        sc_reg <= sc_reg;
                    end
                endcase
            end
        end
        dry_reg     <= dry_next;
        xy_reg      <= xy_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        acc_reg     <= acc_next;
        z1n_reg     <= z1n_next;
        mix_reg     <= mix_next;
        p_reg       <= p_next;
        target_reg  <= target_next;
        y_reg       <= y_next;
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
        m_peak_reg  <= m_peak_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_left_out   = m_left_reg;
    assign m_right_out  = m_right_reg;
    assign m_peak_level = m_peak_reg;

    sbeq_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_coef_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    sbeq_ram #(
        .WIDTH (2 * DLW),
        .DEPTH (DDEPTH)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (daddr),
        .wdata (dly_wdata),
        .re    (dly_re),
        .raddr (daddr),
        .rdata (dly_rdata)
    );

    sbeq_mac #(
        .MA        (MA),
        .MB        (MB),
        .COEF_FRAC (COEF_FRAC)
    ) u_mac (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .sel   (mul_sel),
        .rnd   (rnd)
    );

    sbeq_div #(
        .W (MAGW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (thr_val),
        .den     (p_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    a_coef_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_we |-> (state_reg == ST_IDLE))
        else $error("coefficient write outside idle");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wet_reg <= sbeq_pkg::UNITY) && (gain_reg <= sbeq_pkg::UNITY))
        else $error("wet weight or limiter gain above unity");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result item not presented");

endmodule
